FILE: design/softened_gravity_acceleration_assert.svh
// Assertion helpers for the modules that check themselves.
// Both use the enclosing module's clk and rst.
`ifndef SOFTENED_GRAVITY_ACCELERATION_ASSERT_SVH
`define SOFTENED_GRAVITY_ACCELERATION_ASSERT_SVH

// Same-cycle implication.
`define SGA_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("softened_gravity_acceleration: assertion failed");

// Next-cycle implication.
`define SGA_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("softened_gravity_acceleration: assertion failed");

`endif

FILE: design/sga_pkg.sv
package sga_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int GM_BITS    = 48;
  localparam int SOFT_BITS  = 32;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = GM_BITS;
  localparam logic [SOFT_BITS-1:0] SOFT_RESET = SOFT_BITS'(655);

  // Derived datapath widths.
  localparam int MAG_BITS   = COORD_BITS + 1;
  localparam int S_BITS     = 2 * MAG_BITS;
  localparam int ROOT_BITS  = MAG_BITS;
  localparam int GM_SPLIT   = GM_BITS / 2;
  localparam int PHI_BITS   = GM_BITS - GM_SPLIT + MAG_BITS;
  localparam int PLO_BITS   = GM_SPLIT + MAG_BITS;
  localparam int PROD_BITS  = GM_BITS + MAG_BITS;
  localparam int NUM_BITS   = PROD_BITS + FRAC_BITS;
  localparam int Q_BITS     = GM_BITS + FRAC_BITS;
  localparam int MNUM_BITS  = Q_BITS + FRAC_BITS;
  localparam int PULL_LIMIT_BIT = 61;
  localparam int PULL_BITS    = PULL_LIMIT_BIT + 1;
  localparam int CONTRIB_BITS = PULL_BITS + 1;
  localparam int SUM_BITS     = CONTRIB_BITS + 1;

  localparam logic [MNUM_BITS-1:0] PULL_LIMIT = MNUM_BITS'(1) << PULL_LIMIT_BIT;
  localparam logic signed [SUM_BITS-1:0] SAT_HI = (SUM_BITS'(1) <<< (COORD_BITS - 1)) - 1;
  localparam logic signed [SUM_BITS-1:0] SAT_LO = -SAT_HI - 1;

  // Center pipe: difference, square, sum, root, two product stages,
  // two dividers and the final clamp.
  localparam int CENTER_LAT = 3 + ROOT_BITS + 2 + Q_BITS + MNUM_BITS + 1;
  localparam int LATENCY    = CENTER_LAT + 2;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_GM        = 2'd0,
    REG_SOFTENING = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic                neg;
    logic [MAG_BITS-1:0] mag;
  } axis_t;

  typedef struct packed {
    logic  en;
    logic  zero;
    axis_t x;
    axis_t y;
  } root_side_t;

  typedef struct packed {
    logic [S_BITS-1:0] s;
    logic              neg;
    logic              zero;
    logic              en;
  } pull_side_t;

  typedef struct packed {
    logic                            valid;
    logic                            clip;
    logic signed [CONTRIB_BITS-1:0]  ax;
    logic signed [CONTRIB_BITS-1:0]  ay;
  } center_out_t;

endpackage

FILE: design/sga_isqrt.sv
module sga_isqrt import sga_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [S_BITS-1:0]    in_s,
  input  root_side_t           in_side,
  output logic                 out_valid,
  output logic [ROOT_BITS-1:0] out_root,
  output logic [S_BITS-1:0]    out_s,
  output root_side_t           out_side
);

  // One result bit per stage, two radicand bits consumed per stage.
  logic                 v    [ROOT_BITS];
  logic [ROOT_BITS:0]   rem  [ROOT_BITS];
  logic [ROOT_BITS-1:0] root [ROOT_BITS];
  logic [S_BITS-1:0]    s    [ROOT_BITS];
  root_side_t           side [ROOT_BITS];

  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_step
    logic                 v_p;
    logic [ROOT_BITS:0]   rem_p;
    logic [ROOT_BITS-1:0] root_p;
    logic [S_BITS-1:0]    s_p;
    root_side_t           side_p;
    logic [ROOT_BITS+2:0] cur;
    logic [ROOT_BITS+2:0] trial;
    logic [ROOT_BITS+2:0] diff;
    logic                 take;

    if (k == 0) begin : g_first
      assign v_p    = in_valid;
      assign rem_p  = '0;
      assign root_p = '0;
      assign s_p    = in_s;
      assign side_p = in_side;
    end else begin : g_next
      assign v_p    = v[k-1];
      assign rem_p  = rem[k-1];
      assign root_p = root[k-1];
      assign s_p    = s[k-1];
      assign side_p = side[k-1];
    end

    assign cur   = {rem_p, s_p[S_BITS-1-2*k -: 2]};
    assign trial = {1'b0, root_p, 2'b01};
    assign diff  = cur - trial;
    assign take  = cur >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else begin
        v[k] <= v_p;
      end
      rem[k]  <= take ? diff[ROOT_BITS:0] : cur[ROOT_BITS:0];
      root[k] <= {root_p[ROOT_BITS-2:0], take};
      s[k]    <= s_p;
      side[k] <= side_p;
    end
  end

  assign out_valid = v[ROOT_BITS-1];
  assign out_root  = root[ROOT_BITS-1];
  assign out_s     = s[ROOT_BITS-1];
  assign out_side  = side[ROOT_BITS-1];

endmodule

FILE: design/sga_qdiv.sv
module sga_qdiv import sga_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [NUM_BITS-1:0]  in_num,
  input  logic [ROOT_BITS-1:0] in_den,
  input  pull_side_t           in_side,
  output logic                 out_valid,
  output logic [Q_BITS-1:0]    out_q,
  output pull_side_t           out_side
);

  // The upper numerator bits are already below the divisor, so only the
  // low quotient bits are developed, one per stage.
  logic                 v    [Q_BITS];
  logic [ROOT_BITS-1:0] rem  [Q_BITS];
  logic [Q_BITS-1:0]    shf  [Q_BITS];
  logic [ROOT_BITS-1:0] den  [Q_BITS];
  pull_side_t           side [Q_BITS];

  for (genvar k = 0; k < Q_BITS; k++) begin : g_step
    logic                 v_p;
    logic [ROOT_BITS-1:0] rem_p;
    logic [Q_BITS-1:0]    shf_p;
    logic [ROOT_BITS-1:0] den_p;
    pull_side_t           side_p;
    logic [ROOT_BITS:0]   cur;
    logic [ROOT_BITS:0]   diff;
    logic                 take;

    if (k == 0) begin : g_first
      assign v_p    = in_valid;
      assign rem_p  = in_num[NUM_BITS-1:Q_BITS];
      assign shf_p  = in_num[Q_BITS-1:0];
      assign den_p  = in_den;
      assign side_p = in_side;
    end else begin : g_next
      assign v_p    = v[k-1];
      assign rem_p  = rem[k-1];
      assign shf_p  = shf[k-1];
      assign den_p  = den[k-1];
      assign side_p = side[k-1];
    end

    assign cur  = {rem_p, shf_p[Q_BITS-1]};
    assign diff = cur - {1'b0, den_p};
    assign take = cur >= {1'b0, den_p};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else begin
        v[k] <= v_p;
      end
      rem[k]  <= take ? diff[ROOT_BITS-1:0] : cur[ROOT_BITS-1:0];
      shf[k]  <= {shf_p[Q_BITS-2:0], take};
      den[k]  <= den_p;
      side[k] <= side_p;
    end
  end

  assign out_valid = v[Q_BITS-1];
  assign out_q     = shf[Q_BITS-1];
  assign out_side  = side[Q_BITS-1];

endmodule

FILE: design/sga_mdiv.sv
module sga_mdiv import sga_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [Q_BITS-1:0]    in_q,
  input  pull_side_t           in_side,
  output logic                 out_valid,
  output logic [MNUM_BITS-1:0] out_m,
  output pull_side_t           out_side
);

  // Restoring division of q scaled by 2^16 by the radius sum, one
  // quotient bit per stage. The divisor rides along in the side data.
  logic                 v    [MNUM_BITS];
  logic [S_BITS-1:0]    rem  [MNUM_BITS];
  logic [MNUM_BITS-1:0] shf  [MNUM_BITS];
  pull_side_t           side [MNUM_BITS];

  for (genvar k = 0; k < MNUM_BITS; k++) begin : g_step
    logic                 v_p;
    logic [S_BITS-1:0]    rem_p;
    logic [MNUM_BITS-1:0] shf_p;
    pull_side_t           side_p;
    logic [S_BITS:0]      cur;
    logic [S_BITS:0]      diff;
    logic                 take;

    if (k == 0) begin : g_first
      assign v_p    = in_valid;
      assign rem_p  = '0;
      assign shf_p  = {in_q, {FRAC_BITS{1'b0}}};
      assign side_p = in_side;
    end else begin : g_next
      assign v_p    = v[k-1];
      assign rem_p  = rem[k-1];
      assign shf_p  = shf[k-1];
      assign side_p = side[k-1];
    end

    assign cur  = {rem_p, shf_p[MNUM_BITS-1]};
    assign diff = cur - {1'b0, side_p.s};
    assign take = cur >= {1'b0, side_p.s};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else begin
        v[k] <= v_p;
      end
      rem[k]  <= take ? diff[S_BITS-1:0] : cur[S_BITS-1:0];
      shf[k]  <= {shf_p[MNUM_BITS-2:0], take};
      side[k] <= side_p;
    end
  end

  assign out_valid = v[MNUM_BITS-1];
  assign out_m     = shf[MNUM_BITS-1];
  assign out_side  = side[MNUM_BITS-1];

endmodule

FILE: design/sga_center.sv
module sga_center import sga_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_en,
  input  logic signed [COORD_BITS-1:0] in_body_x,
  input  logic signed [COORD_BITS-1:0] in_body_y,
  input  logic signed [COORD_BITS-1:0] in_center_x,
  input  logic signed [COORD_BITS-1:0] in_center_y,
  input  logic [GM_BITS-1:0]           gm,
  input  logic [SOFT_BITS-1:0]         softening,
  output center_out_t                  out
);

  function automatic axis_t to_axis(input logic signed [MAG_BITS-1:0] d);
    axis_t a;
    a.neg = d[MAG_BITS-1];
    a.mag = a.neg ? MAG_BITS'(-d) : MAG_BITS'(d);
    return a;
  endfunction

  // Stage 1: differences.
  logic signed [MAG_BITS-1:0] dx;
  logic signed [MAG_BITS-1:0] dy;
  logic  v1;
  logic  en1;
  axis_t ax1;
  axis_t ay1;

  assign dx = MAG_BITS'(in_body_x) - MAG_BITS'(in_center_x);
  assign dy = MAG_BITS'(in_body_y) - MAG_BITS'(in_center_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    en1 <= in_en;
    ax1 <= to_axis(dx);
    ay1 <= to_axis(dy);
  end

  // Stage 2: squares.
  logic              v2;
  logic              en2;
  axis_t             ax2;
  axis_t             ay2;
  logic [S_BITS-1:0] sqx2;
  logic [S_BITS-1:0] sqy2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    en2  <= en1;
    ax2  <= ax1;
    ay2  <= ay1;
    sqx2 <= ax1.mag * ax1.mag;
    sqy2 <= ay1.mag * ay1.mag;
  end

  // Stage 3: softened radius sum.
  logic [S_BITS-1:0] s_sum;
  logic              v3;
  logic [S_BITS-1:0] s3;
  root_side_t        side3;

  assign s_sum = sqx2 + sqy2 + (S_BITS'(softening) << FRAC_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    s3         <= s_sum;
    side3.en   <= en2;
    side3.zero <= (s_sum == '0);
    side3.x    <= ax2;
    side3.y    <= ay2;
  end

  logic                 r_valid;
  logic [ROOT_BITS-1:0] r_root;
  logic [S_BITS-1:0]    r_s;
  root_side_t           r_side;

  sga_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v3),
    .in_s     (s3),
    .in_side  (side3),
    .out_valid(r_valid),
    .out_root (r_root),
    .out_s    (r_s),
    .out_side (r_side)
  );

  // Product stage 1: split partial products. A zero sum gets unit divisors
  // so the dividers stay defined; its result is dropped at the end.
  logic                 v4;
  logic [PHI_BITS-1:0]  px_hi4;
  logic [PLO_BITS-1:0]  px_lo4;
  logic [PHI_BITS-1:0]  py_hi4;
  logic [PLO_BITS-1:0]  py_lo4;
  logic [ROOT_BITS-1:0] den4;
  logic [S_BITS-1:0]    s4;
  root_side_t           side4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= r_valid;
    end
    px_hi4 <= gm[GM_BITS-1:GM_SPLIT] * r_side.x.mag;
    px_lo4 <= gm[GM_SPLIT-1:0] * r_side.x.mag;
    py_hi4 <= gm[GM_BITS-1:GM_SPLIT] * r_side.y.mag;
    py_lo4 <= gm[GM_SPLIT-1:0] * r_side.y.mag;
    den4   <= r_side.zero ? ROOT_BITS'(1) : r_root;
    s4     <= r_side.zero ? S_BITS'(1) : r_s;
    side4  <= r_side;
  end

  // Product stage 2: recombine and scale to the division numerator.
  logic                 v5;
  logic [NUM_BITS-1:0]  num_x5;
  logic [NUM_BITS-1:0]  num_y5;
  logic [ROOT_BITS-1:0] den5;
  pull_side_t           side_x5;
  pull_side_t           side_y5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    num_x5 <= NUM_BITS'((PROD_BITS'(px_hi4) << GM_SPLIT) + PROD_BITS'(px_lo4)) << FRAC_BITS;
    num_y5 <= NUM_BITS'((PROD_BITS'(py_hi4) << GM_SPLIT) + PROD_BITS'(py_lo4)) << FRAC_BITS;
    den5   <= den4;
    side_x5 <= '{s: s4, neg: side4.x.neg, zero: side4.zero, en: side4.en};
    side_y5 <= '{s: s4, neg: side4.y.neg, zero: side4.zero, en: side4.en};
  end

  logic              q_vx;
  logic              q_vy;
  logic [Q_BITS-1:0] q_x;
  logic [Q_BITS-1:0] q_y;
  pull_side_t        q_side_x;
  pull_side_t        q_side_y;

  sga_qdiv u_qdiv_x (
    .clk(clk), .rst(rst),
    .in_valid(v5), .in_num(num_x5), .in_den(den5), .in_side(side_x5),
    .out_valid(q_vx), .out_q(q_x), .out_side(q_side_x)
  );

  sga_qdiv u_qdiv_y (
    .clk(clk), .rst(rst),
    .in_valid(v5), .in_num(num_y5), .in_den(den5), .in_side(side_y5),
    .out_valid(q_vy), .out_q(q_y), .out_side(q_side_y)
  );

  logic                 m_vx;
  logic                 m_vy;
  logic [MNUM_BITS-1:0] m_x;
  logic [MNUM_BITS-1:0] m_y;
  pull_side_t           m_side_x;
  pull_side_t           m_side_y;

  sga_mdiv u_mdiv_x (
    .clk(clk), .rst(rst),
    .in_valid(q_vx), .in_q(q_x), .in_side(q_side_x),
    .out_valid(m_vx), .out_m(m_x), .out_side(m_side_x)
  );

  sga_mdiv u_mdiv_y (
    .clk(clk), .rst(rst),
    .in_valid(q_vy), .in_q(q_y), .in_side(q_side_y),
    .out_valid(m_vy), .out_m(m_y), .out_side(m_side_y)
  );

  // Final stage: clamp, apply the sign (pull points toward the center).
  logic                           over_x;
  logic                           over_y;
  logic                           live;
  logic signed [CONTRIB_BITS-1:0] mag_x;
  logic signed [CONTRIB_BITS-1:0] mag_y;

  assign over_x = m_x > PULL_LIMIT;
  assign over_y = m_y > PULL_LIMIT;
  assign live   = m_side_x.en && !m_side_x.zero;
  assign mag_x  = $signed(CONTRIB_BITS'(over_x ? PULL_LIMIT[PULL_BITS-1:0]
                                               : m_x[PULL_BITS-1:0]));
  assign mag_y  = $signed(CONTRIB_BITS'(over_y ? PULL_LIMIT[PULL_BITS-1:0]
                                               : m_y[PULL_BITS-1:0]));

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else begin
      out.valid <= m_vx && m_vy;
    end
    out.clip <= m_side_x.en && (m_side_x.zero || over_x || over_y);
    out.ax   <= !live ? '0 : (m_side_x.neg ? mag_x : -mag_x);
    out.ay   <= !live ? '0 : (m_side_y.neg ? mag_y : -mag_y);
  end

endmodule

FILE: design/softened_gravity_acceleration.sv
// Softened (Plummer) gravitational acceleration of a body toward one or two
// point centers, in signed Q16.16 fixed point.
//
// Input: an item is accepted on a rising edge where start is high and busy is
// low. busy never rises, so an item may be offered in every cycle. mode picks
// one center (first) or two (first and second); second center fields are
// ignored in one-center mode.
// Output: done is high for one cycle with accel_x, accel_y and clipped. The
// receiver cannot hold results off, and none is needed: results leave in the
// order items came in, one per cycle at most.
// Pipeline: every item passes through the per-bit division stages (64 for the
// first quotient, 80 for the second), 33 square root stages and 8 register
// stages for input, difference, square, sum, product split, product join,
// clamp and output. Throughput is one item per cycle.
// Configuration: gm (index 0) and softening (index 1) are written through
// cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is always high.
// Write them only while no item is in flight.
// Reset: synchronous rst empties the pipeline and sets gm to 0 and softening
// to 655 (about 0.01).
`include "softened_gravity_acceleration_assert.svh"

module softened_gravity_acceleration import sga_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         mode,
  input  logic signed [COORD_BITS-1:0] body_x,
  input  logic signed [COORD_BITS-1:0] body_y,
  input  logic signed [COORD_BITS-1:0] first_center_x,
  input  logic signed [COORD_BITS-1:0] first_center_y,
  input  logic signed [COORD_BITS-1:0] second_center_x,
  input  logic signed [COORD_BITS-1:0] second_center_y,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [CFG_DATA_BITS-1:0]     cfg_data,
  output logic                         done,
  output logic signed [COORD_BITS-1:0] accel_x,
  output logic signed [COORD_BITS-1:0] accel_y,
  output logic                         clipped
);

  // The pipeline never stalls, so the block is always ready for a new beat.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  logic [GM_BITS-1:0]   gm;
  logic [SOFT_BITS-1:0] softening;

  always_ff @(posedge clk) begin
    if (rst) begin
      gm        <= '0;
      softening <= SOFT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_GM:        gm        <= cfg_data;
        REG_SOFTENING: softening <= cfg_data[SOFT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input register: captures the beat on acceptance.
  logic                         s0_valid;
  logic                         s0_mode;
  logic signed [COORD_BITS-1:0] s0_bx;
  logic signed [COORD_BITS-1:0] s0_by;
  logic signed [COORD_BITS-1:0] s0_c1x;
  logic signed [COORD_BITS-1:0] s0_c1y;
  logic signed [COORD_BITS-1:0] s0_c2x;
  logic signed [COORD_BITS-1:0] s0_c2y;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= start && !busy;
    end
    s0_mode <= mode;
    s0_bx   <= body_x;
    s0_by   <= body_y;
    s0_c1x  <= first_center_x;
    s0_c1y  <= first_center_y;
    s0_c2x  <= second_center_x;
    s0_c2y  <= second_center_y;
  end

  // Two identical center pipes run in lockstep. The second one is enabled
  // only in two-center mode; when disabled it contributes zero and never
  // flags a clip.
  center_out_t ca_out;
  center_out_t cb_out;

  sga_center u_center_a (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s0_valid),
    .in_en      (1'b1),
    .in_body_x  (s0_bx),
    .in_body_y  (s0_by),
    .in_center_x(s0_c1x),
    .in_center_y(s0_c1y),
    .gm         (gm),
    .softening  (softening),
    .out        (ca_out)
  );

  sga_center u_center_b (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s0_valid),
    .in_en      (s0_mode),
    .in_body_x  (s0_bx),
    .in_body_y  (s0_by),
    .in_center_x(s0_c2x),
    .in_center_y(s0_c2y),
    .gm         (gm),
    .softening  (softening),
    .out        (cb_out)
  );

  // Sum the two contributions and saturate to the coordinate range.
  logic signed [SUM_BITS-1:0] sum_x;
  logic signed [SUM_BITS-1:0] sum_y;
  logic signed [SUM_BITS-1:0] sat_x;
  logic signed [SUM_BITS-1:0] sat_y;
  logic                       sat_hit;

  assign sum_x = SUM_BITS'(ca_out.ax) + SUM_BITS'(cb_out.ax);
  assign sum_y = SUM_BITS'(ca_out.ay) + SUM_BITS'(cb_out.ay);

  always_comb begin
    sat_x   = sum_x;
    sat_y   = sum_y;
    sat_hit = 1'b0;
    if (sum_x > SAT_HI) begin
      sat_x   = SAT_HI;
      sat_hit = 1'b1;
    end else if (sum_x < SAT_LO) begin
      sat_x   = SAT_LO;
      sat_hit = 1'b1;
    end
    if (sum_y > SAT_HI) begin
      sat_y   = SAT_HI;
      sat_hit = 1'b1;
    end else if (sum_y < SAT_LO) begin
      sat_y   = SAT_LO;
      sat_hit = 1'b1;
    end
  end

  // Output register: the result beat is shown for exactly one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ca_out.valid;
    end
    accel_x <= sat_x[COORD_BITS-1:0];
    accel_y <= sat_y[COORD_BITS-1:0];
    clipped <= ca_out.clip || cb_out.clip || sat_hit;
  end

  `SGA_ASSERT_IMPL(a_lockstep, ca_out.valid || cb_out.valid, ca_out.valid && cb_out.valid)
  `SGA_ASSERT_IMPL(a_latency, start && !busy, ##LATENCY done)
  `SGA_ASSERT_NEXT(a_sat_flag, ca_out.valid && (sum_x > SAT_HI || sum_x < SAT_LO), clipped && done)
  `SGA_ASSERT_NEXT(a_center_clip, ca_out.valid && (ca_out.clip || cb_out.clip), clipped)

endmodule

FILE: bench/sga_checker.sv
module sga_checker import sga_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         busy,
  input  logic                         mode,
  input  logic signed [COORD_BITS-1:0] body_x,
  input  logic signed [COORD_BITS-1:0] body_y,
  input  logic signed [COORD_BITS-1:0] first_center_x,
  input  logic signed [COORD_BITS-1:0] first_center_y,
  input  logic signed [COORD_BITS-1:0] second_center_x,
  input  logic signed [COORD_BITS-1:0] second_center_y,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [CFG_DATA_BITS-1:0]     cfg_data,
  input  logic                         done,
  input  logic signed [COORD_BITS-1:0] accel_x,
  input  logic signed [COORD_BITS-1:0] accel_y,
  input  logic                         clipped,
  output int                           errors,
  output int                           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic                         clip;
  } accel_t;

  accel_t                accel_pending_q[$];
  logic [GM_BITS-1:0]    gm_copy;
  logic [SOFT_BITS-1:0]  soft_copy;

  assign pending = accel_pending_q.size();

  function automatic logic [63:0] root_floor(logic [127:0] s);
    logic [63:0] res;
    logic [63:0] c;
    res = '0;
    for (int b = 63; b >= 0; b--) begin
      c = res | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= s) res = c;
    end
    return res;
  endfunction

  // Pull along one axis: magnitude gm*|d|/s^1.5, sign opposite to d.
  function automatic logic signed [63:0] axis_pull(logic signed [COORD_BITS:0] d,
                                                   logic [127:0] s, logic [63:0] r,
                                                   inout logic clip);
    logic [127:0] mag;
    logic [127:0] q;
    logic [127:0] m;
    mag = d < 0 ? 128'(-d) : 128'(d);
    if (mag == 0) return 0;
    q = (({80'd0, gm_copy} * mag) << FRAC_BITS) / {64'd0, r};
    m = ({64'd0, q[63:0]} << FRAC_BITS) / s;
    if (m > (128'd1 << PULL_LIMIT_BIT)) begin
      m = 128'd1 << PULL_LIMIT_BIT;
      clip = 1'b1;
    end
    return d > 0 ? -$signed(m[63:0]) : $signed(m[63:0]);
  endfunction

  function automatic void center_pull(logic signed [COORD_BITS-1:0] bx, by, cx, cy,
                                      inout logic signed [63:0] ax, ay,
                                      inout logic clip);
    logic signed [COORD_BITS:0] dx;
    logic signed [COORD_BITS:0] dy;
    logic [127:0] mx;
    logic [127:0] my;
    logic [127:0] s;
    logic [63:0]  r;
    dx = {bx[COORD_BITS-1], bx} - {cx[COORD_BITS-1], cx};
    dy = {by[COORD_BITS-1], by} - {cy[COORD_BITS-1], cy};
    mx = dx < 0 ? 128'(-dx) : 128'(dx);
    my = dy < 0 ? 128'(-dy) : 128'(dy);
    s = mx * mx + my * my + ({96'd0, soft_copy} << FRAC_BITS);
    if (s == 0) begin
      clip = 1'b1;
      return;
    end
    r = root_floor(s);
    ax += axis_pull(dx, s, r, clip);
    ay += axis_pull(dy, s, r, clip);
  endfunction

  function automatic logic signed [COORD_BITS-1:0] clamp_out(logic signed [63:0] v,
                                                             inout logic clip);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (COORD_BITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      v = hi;
      clip = 1'b1;
    end
    if (v < lo) begin
      v = lo;
      clip = 1'b1;
    end
    return v[COORD_BITS-1:0];
  endfunction

  function automatic accel_t predict_accel();
    accel_t              e;
    logic signed [63:0]  ax;
    logic signed [63:0]  ay;
    logic                clip;
    ax = 0;
    ay = 0;
    clip = 1'b0;
    center_pull(body_x, body_y, first_center_x, first_center_y, ax, ay, clip);
    if (mode)
      center_pull(body_x, body_y, second_center_x, second_center_y, ax, ay, clip);
    e.ax = clamp_out(ax, clip);
    e.ay = clamp_out(ay, clip);
    e.clip = clip;
    return e;
  endfunction

  initial errors = 0;

  always @(posedge clk) begin
    accel_t e;
    if (rst) begin
      gm_copy <= '0;
      soft_copy <= SOFT_RESET;
      accel_pending_q.delete();
    end else begin
      // A result leaving in the same cycle as an item enters is checked first,
      // so the queue order matches the pipeline order.
      if (done) begin
        if (accel_pending_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("Unexpected result beat at %0t", $time);
        end else begin
          e = accel_pending_q.pop_front();
          if (e.ax !== accel_x || e.ay !== accel_y || e.clip !== clipped) begin
            errors++;
            if (errors <= 10)
              $display("Mismatch at %0t: expected ax=%0d ay=%0d clip=%0b, got ax=%0d ay=%0d clip=%0b",
                       $time, e.ax, e.ay, e.clip, accel_x, accel_y, clipped);
          end
        end
      end
      if (start && !busy) accel_pending_q.push_back(predict_accel());
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_GM:        gm_copy <= cfg_data[GM_BITS-1:0];
          REG_SOFTENING: soft_copy <= cfg_data[SOFT_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: bench/tb_softened_gravity_acceleration.sv
module tb_softened_gravity_acceleration;
  import sga_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         start = 1'b0;
  logic                         busy;
  logic                         mode = 1'b0;
  logic signed [COORD_BITS-1:0] body_x = '0;
  logic signed [COORD_BITS-1:0] body_y = '0;
  logic signed [COORD_BITS-1:0] first_center_x = '0;
  logic signed [COORD_BITS-1:0] first_center_y = '0;
  logic signed [COORD_BITS-1:0] second_center_x = '0;
  logic signed [COORD_BITS-1:0] second_center_y = '0;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [CFG_INDEX_BITS-1:0]    cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]     cfg_data = '0;
  logic                         done;
  logic signed [COORD_BITS-1:0] accel_x;
  logic signed [COORD_BITS-1:0] accel_y;
  logic                         clipped;
  int                           errors;
  int                           pending;
  int                           idle_cycles = 0;

  // Every item passes through the pipe well within this limit, so a stall that
  // long with nothing moving means the block has hung.
  localparam int WATCHDOG_LIMIT = 20 * LATENCY + 2000;

  always #5 clk = ~clk;

  softened_gravity_acceleration dut (.*);

  sga_checker checker_i (.*);

  // Count cycles in which no beat moves on any channel.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Mostly no gap, sometimes a short one and rarely a long one, so that
  // bubbles land at every depth of the pipe.
  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 80);
  endfunction

  // Positions over many scales: full range, shifted down, and tiny.
  function automatic logic signed [COORD_BITS-1:0] rand_coord();
    logic signed [COORD_BITS-1:0] v;
    v = $urandom;
    case ($urandom_range(0, 3))
      0: return v;
      1: return v >>> $urandom_range(4, 20);
      2: return v >>> $urandom_range(20, 31);
      default: return v >>> $urandom_range(10, 16);
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_beat(input logic m, input logic signed [COORD_BITS-1:0] bx, by,
                           c1x, c1y, c2x, c2y);
    logic was_busy;
    start = 1'b1;
    mode = m;
    body_x = bx;
    body_y = by;
    first_center_x = c1x;
    first_center_y = c1y;
    second_center_x = c2x;
    second_center_y = c2y;
    do begin
      was_busy = busy;
      @(posedge clk);
      @(negedge clk);
    end while (was_busy);
  endtask

  task automatic idle_for(input int n);
    start = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Register writes only go out with the pipe empty. Every item yields a
  // result, so an empty expectation queue means nothing is in flight.
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] val);
    logic was_ready;
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do begin
      was_ready = cfg_ready;
      @(posedge clk);
      @(negedge clk);
    end while (!was_ready);
    cfg_valid = 1'b0;
  endtask

  // One random item: the centers usually sit near the body so that the
  // pull lands inside the output range, sometimes anywhere at all.
  task automatic send_random();
    logic signed [COORD_BITS-1:0] bx, by;
    logic signed [COORD_BITS-1:0] c1x, c1y, c2x, c2y;
    bx = rand_coord();
    by = rand_coord();
    if ($urandom_range(0, 3) != 0) begin
      c1x = bx + (rand_coord() >>> $urandom_range(0, 12));
      c1y = by + (rand_coord() >>> $urandom_range(0, 12));
      c2x = bx + (rand_coord() >>> $urandom_range(0, 12));
      c2y = by + (rand_coord() >>> $urandom_range(0, 12));
    end else begin
      c1x = rand_coord();
      c1y = rand_coord();
      c2x = rand_coord();
      c2y = rand_coord();
    end
    send_beat($urandom_range(0, 1), bx, by, c1x, c1y, c2x, c2y);
    idle_for(gap_len());
  endtask

  localparam logic signed [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam logic signed [COORD_BITS-1:0] ONE  = 1 <<< FRAC_BITS;

  initial begin
    logic [GM_BITS-1:0] gm_val;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed items run with the reset softening and a moderate mass.
    write_reg(REG_GM, 48'd1 << 40);
    // Body on the center, softening only keeps the denominator off zero.
    send_beat(1'b0, ONE, ONE, ONE, ONE, CMAX, CMIN);
    // Unit offsets on each axis, both signs, and both modes.
    send_beat(1'b0, ONE, 0, 0, 0, 0, 0);
    send_beat(1'b0, 0, -ONE, 0, 0, 0, 0);
    send_beat(1'b1, 0, 0, ONE, ONE, -ONE, -ONE);
    send_beat(1'b1, 0, 0, ONE, 0, ONE, 0);
    // Corners of the coordinate range give the widest differences.
    send_beat(1'b0, CMAX, CMAX, CMIN, CMIN, 0, 0);
    send_beat(1'b1, CMIN, CMAX, CMAX, CMIN, CMIN, CMIN);
    send_beat(1'b0, CMIN, CMIN, CMIN, CMIN, CMAX, CMAX);
    // Tiny separations produce a huge pull that saturates.
    send_beat(1'b0, 1, 1, 0, 0, 0, 0);
    send_beat(1'b1, 1, 0, 0, 0, 2, 0);
    idle_for(3);

    // Zero softening: a body sitting on a center has no denominator.
    write_reg(REG_SOFTENING, 32'd0);
    send_beat(1'b0, ONE, -ONE, ONE, -ONE, 0, 0);
    send_beat(1'b1, 0, 0, 0, 0, ONE, 0);
    send_beat(1'b1, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN);
    // The largest mass pins nearly everything at the clamp.
    write_reg(REG_GM, {GM_BITS{1'b1}});
    send_beat(1'b0, 1, 0, 0, 0, 0, 0);
    send_beat(1'b1, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX);
    // The widest softening flattens the field out.
    write_reg(REG_SOFTENING, {SOFT_BITS{1'b1}});
    send_beat(1'b0, ONE, ONE, 0, 0, 0, 0);
    send_beat(1'b1, CMIN, 0, CMAX, 0, 0, CMAX);
    // No mass at all: every pull is zero.
    write_reg(REG_GM, '0);
    send_beat(1'b1, ONE, ONE, 0, 0, CMAX, CMIN);
    idle_for(2);

    // Random phases, each with its own setting of both registers.
    for (int phase = 0; phase < 8; phase++) begin
      case ($urandom_range(0, 3))
        0: gm_val = {GM_BITS{1'b1}};
        1: gm_val = '0;
        default: gm_val = {$urandom, $urandom} >> $urandom_range(0, 47);
      endcase
      write_reg(REG_GM, gm_val);
      case ($urandom_range(0, 3))
        0: write_reg(REG_SOFTENING, 32'd0);
        1: write_reg(REG_SOFTENING, {SOFT_BITS{1'b1}});
        default: write_reg(REG_SOFTENING, $urandom >> $urandom_range(0, 31));
      endcase
      for (int i = 0; i < 50; i++) begin
        send_random();
        // Once, the sender holds off until the pipe has drained.
        if (phase == 3 && i == 25) begin
          start = 1'b0;
          while (pending != 0) @(negedge clk);
        end
      end
    end
    start = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 20) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
